### src/ialu_pkg.sv
// Shared types and opcode constants for the 64-bit integer ALU with NZCV flags.
// No dependencies; imported by ialu_core, integer_alu_with_flags, ialu_result_checker and tb.
package ialu_pkg;

    localparam int DATA_W = 64;
    localparam int OP_W   = 6;
    localparam int TAG_W  = 6;
    localparam int SH_W   = 6;

    localparam logic [OP_W-1:0] OP_ADD    = 6'h00;
    localparam logic [OP_W-1:0] OP_ADD_A  = 6'h0E;
    localparam logic [OP_W-1:0] OP_SUB    = 6'h01;
    localparam logic [OP_W-1:0] OP_SUB_A  = 6'h0F;
    localparam logic [OP_W-1:0] OP_ADC    = 6'h02;
    localparam logic [OP_W-1:0] OP_ADC_A  = 6'h10;
    localparam logic [OP_W-1:0] OP_SBC    = 6'h03;
    localparam logic [OP_W-1:0] OP_SBC_A  = 6'h11;
    localparam logic [OP_W-1:0] OP_INC    = 6'h1C;
    localparam logic [OP_W-1:0] OP_DEC    = 6'h1D;
    localparam logic [OP_W-1:0] OP_AND    = 6'h06;
    localparam logic [OP_W-1:0] OP_AND_A  = 6'h14;
    localparam logic [OP_W-1:0] OP_ORR    = 6'h07;
    localparam logic [OP_W-1:0] OP_ORR_A  = 6'h15;
    localparam logic [OP_W-1:0] OP_EOR    = 6'h08;
    localparam logic [OP_W-1:0] OP_EOR_A  = 6'h16;
    localparam logic [OP_W-1:0] OP_BIC    = 6'h09;
    localparam logic [OP_W-1:0] OP_BIC_A  = 6'h17;
    localparam logic [OP_W-1:0] OP_LSL    = 6'h0A;
    localparam logic [OP_W-1:0] OP_LSL_A  = 6'h18;
    localparam logic [OP_W-1:0] OP_LSR    = 6'h0B;
    localparam logic [OP_W-1:0] OP_LSR_A  = 6'h19;
    localparam logic [OP_W-1:0] OP_ASR    = 6'h0C;
    localparam logic [OP_W-1:0] OP_ASR_A  = 6'h1A;
    localparam logic [OP_W-1:0] OP_ROR    = 6'h0D;
    localparam logic [OP_W-1:0] OP_ROR_A  = 6'h1B;
    localparam logic [OP_W-1:0] OP_MOV    = 6'h31;
    localparam logic [OP_W-1:0] OP_MOV_A  = 6'h33;
    localparam logic [OP_W-1:0] OP_MOV_B  = 6'h35;
    localparam logic [OP_W-1:0] OP_MVN    = 6'h32;
    localparam logic [OP_W-1:0] OP_MVN_A  = 6'h34;
    localparam logic [OP_W-1:0] OP_SFLIP  = 6'h36;
    localparam logic [OP_W-1:0] OP_CMP    = 6'h37;
    localparam logic [OP_W-1:0] OP_CMP_A  = 6'h3B;
    localparam logic [OP_W-1:0] OP_CMN    = 6'h38;
    localparam logic [OP_W-1:0] OP_CMN_A  = 6'h3C;
    localparam logic [OP_W-1:0] OP_TST    = 6'h39;
    localparam logic [OP_W-1:0] OP_TST_A  = 6'h3D;
    localparam logic [OP_W-1:0] OP_TEQ    = 6'h3A;
    localparam logic [OP_W-1:0] OP_TEQ_A  = 6'h3E;

    localparam logic [DATA_W-1:0] SIGN_MASK = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [3:0]        flags_in;
        logic              use_carry_in;
        logic              update_flags;
        logic [TAG_W-1:0]  tag;
    } t_alu_req;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic [3:0]        flags_out;
        logic              flags_valid;
        logic [TAG_W-1:0]  tag;
    } t_alu_rsp;

endpackage

### src/ialu_core.sv
// Combinational datapath of the ALU: one adder, logic unit, shifter and flag logic.
// Depends on ialu_pkg for opcodes and request/response types.
module ialu_core
    import ialu_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [SH_W-1:0]   sh;
    logic [SH_W-1:0]   sh_neg;
    logic [SH_W-1:0]   sh_dec;
    logic              cin;
    logic [DATA_W-1:0] add_b;
    logic              add_c;
    logic [DATA_W:0]   sum;
    logic              add_v;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] fsrc;
    logic              c;
    logic              v;
    logic              cmp;

    assign a      = i_req.operand_a;
    assign b      = i_req.operand_b;
    assign sh     = b[SH_W-1:0];
    assign sh_neg = SH_W'(0) - sh;
    assign sh_dec = sh - SH_W'(1);
    assign cin    = i_req.use_carry_in & i_req.flags_in[1];

    always_comb begin
        case (i_req.opcode)
            OP_SUB, OP_SUB_A, OP_CMP, OP_CMP_A: begin
                add_b = ~b;
                add_c = 1'b1;
            end
            OP_ADC, OP_ADC_A: begin
                add_b = b;
                add_c = cin;
            end
            OP_SBC, OP_SBC_A: begin
                add_b = ~b;
                add_c = cin;
            end
            OP_INC: begin
                add_b = '0;
                add_c = 1'b1;
            end
            OP_DEC: begin
                add_b = '1;
                add_c = 1'b0;
            end
            default: begin
                add_b = b;
                add_c = 1'b0;
            end
        endcase
    end

    assign sum   = {1'b0, a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_c};
    assign add_v = ~(a[DATA_W-1] ^ add_b[DATA_W-1]) & (a[DATA_W-1] ^ sum[DATA_W-1]);

    always_comb begin
        res  = '0;
        fsrc = '0;
        c    = 1'b0;
        v    = 1'b0;
        cmp  = 1'b0;
        case (i_req.opcode)
            OP_ADD, OP_ADD_A, OP_SUB, OP_SUB_A, OP_ADC, OP_ADC_A,
            OP_SBC, OP_SBC_A, OP_INC, OP_DEC: begin
                res = sum[DATA_W-1:0];
                c   = sum[DATA_W];
                v   = add_v;
            end
            OP_AND, OP_AND_A: res = a & b;
            OP_ORR, OP_ORR_A: res = a | b;
            OP_EOR, OP_EOR_A: res = a ^ b;
            OP_BIC, OP_BIC_A: res = a & ~b;
            OP_LSL, OP_LSL_A: begin
                res = a << sh;
                c   = (sh != '0) & a[sh_neg];
            end
            OP_LSR, OP_LSR_A: begin
                res = a >> sh;
                c   = (sh != '0) & a[sh_dec];
            end
            OP_ASR, OP_ASR_A: begin
                res = DATA_W'($signed(a) >>> sh);
                c   = (sh != '0) & a[sh_dec];
            end
            OP_ROR, OP_ROR_A: begin
                res = DATA_W'({a, a} >> sh);
                c   = (sh != '0) & a[sh_dec];
            end
            OP_MOV, OP_MOV_A, OP_MOV_B: res = b;
            OP_MVN, OP_MVN_A:           res = ~b;
            OP_SFLIP:                   res = b ^ SIGN_MASK;
            OP_CMP, OP_CMP_A, OP_CMN, OP_CMN_A: begin
                fsrc = sum[DATA_W-1:0];
                c    = sum[DATA_W];
                v    = add_v;
                cmp  = 1'b1;
            end
            OP_TST, OP_TST_A: begin
                fsrc = a & b;
                cmp  = 1'b1;
            end
            OP_TEQ, OP_TEQ_A: begin
                fsrc = a ^ b;
                cmp  = 1'b1;
            end
            default: res = '0;
        endcase
    end

    logic [DATA_W-1:0] nz_src;
    assign nz_src = cmp ? fsrc : res;

    assign o_rsp.result_value = res;
    assign o_rsp.flags_out    = i_req.update_flags
                              ? {nz_src[DATA_W-1], (nz_src == '0), c, v} : 4'b0;
    assign o_rsp.flags_valid  = i_req.update_flags;
    assign o_rsp.tag          = i_req.tag;

endmodule

### src/integer_alu_with_flags.sv
// Top level of the 64-bit integer ALU with NZCV flags: input register, datapath, result register.
// Depends on ialu_pkg and ialu_core.
//
// Usage:
//   Input channel: i_valid with i_opcode, i_operand_a/b, i_flags_in, i_use_carry_in,
//   i_update_flags, i_dest_tag; a request is taken when i_valid is high and o_stall low.
//   Output channel: o_valid with o_result_value, o_flags_out, o_flags_valid,
//   o_result_tag; a result is taken when o_valid is high and i_stall low.
//   Every request gives exactly one result, in order.
//   A taken request passes the input register, then the result register, before o_valid
//   rises with its result.
//   Throughput: one request per cycle while o_stall is low; the whole operation is one pass
//   through the datapath between the two registers.
//   Result tag is the destination tag modulo TAG_ENTRIES.
//   Reset (i_rst_n low, synchronous) empties both registers; o_valid drops.
//   When the receiver stalls, the result holds; the input register still fills, and
//   o_stall rises only once both registers hold work.
module integer_alu_with_flags
    import ialu_pkg::*;
#(
    parameter int TAG_ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    input  logic [3:0]        i_flags_in,
    input  logic              i_use_carry_in,
    input  logic              i_update_flags,
    input  logic [TAG_W-1:0]  i_dest_tag,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_result_value,
    output logic [3:0]        o_flags_out,
    output logic              o_flags_valid,
    output logic [TAG_W-1:0]  o_result_tag
);

    localparam int TAG_CODES = 1 << TAG_W;

    logic [TAG_W-1:0] tag_mod_lut [TAG_CODES];

    for (genvar g = 0; g < TAG_CODES; g++) begin : g_tag_lut
        assign tag_mod_lut[g] = TAG_W'(g % TAG_ENTRIES);
    end

    t_alu_req r_req;
    t_alu_req n_req;
    logic     r_req_vld;
    t_alu_rsp r_rsp;
    t_alu_rsp n_rsp;
    logic     r_rsp_vld;
    logic     adv_out;
    logic     adv_in;

    assign adv_out = !r_rsp_vld || !i_stall;
    assign adv_in  = !r_req_vld || adv_out;
    assign o_stall = !adv_in;

    always_comb begin
        n_req.opcode       = i_opcode;
        n_req.operand_a    = i_operand_a;
        n_req.operand_b    = i_operand_b;
        n_req.flags_in     = i_flags_in;
        n_req.use_carry_in = i_use_carry_in;
        n_req.update_flags = i_update_flags;
        n_req.tag          = tag_mod_lut[i_dest_tag];
    end

    ialu_core u_core (
        .i_req (r_req),
        .o_rsp (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (adv_in) begin
                r_req_vld <= i_valid;
            end
            if (adv_out) begin
                r_rsp_vld <= r_req_vld;
            end
        end
        if (adv_in && i_valid) begin
            r_req <= n_req;
        end
        if (adv_out && r_req_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid        = r_rsp_vld;
    assign o_result_value = r_rsp.result_value;
    assign o_flags_out    = r_rsp.flags_out;
    assign o_flags_valid  = r_rsp.flags_valid;
    assign o_result_tag   = r_rsp.tag;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_req_vld && r_rsp_vld))
        else $error("input stalled while a register is empty");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_req_vld)
        else $error("accepted request not held in input register");

    a_move_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_vld && adv_out) |=> r_rsp_vld)
        else $error("request lost between input and result register");

    a_tag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({3'b000, o_result_tag} < 9'(TAG_ENTRIES)))
        else $error("result tag beyond tag entries");

    a_flags_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_flags_valid) |-> (o_flags_out == 4'b0))
        else $error("flags driven without flag update");

endmodule

### dv/ialu_result_checker.sv
`timescale 1ns / 100ps
// Result checker for integer_alu_with_flags: watches both channels, predicts each result.
// Keeps the results still to come in order and compares every returned result against them.
// Depends on ialu_pkg.
module ialu_result_checker
    import ialu_pkg::*;
#(
    parameter int TAG_ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_stall,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    input  logic [3:0]        i_flags_in,
    input  logic              i_use_carry_in,
    input  logic              i_update_flags,
    input  logic [TAG_W-1:0]  i_dest_tag,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_stall,
    input  logic [DATA_W-1:0] i_result_value,
    input  logic [3:0]        i_flags_out,
    input  logic              i_flags_valid,
    input  logic [TAG_W-1:0]  i_result_tag,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [DATA_W-1:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

    t_alu_rsp pending_results[$];
    t_alu_req req_seen;
    t_alu_rsp want;
    int       fails = 0;

    function automatic logic [DATA_W-1:0] add_carry(input logic [DATA_W-1:0] x, y,
                                                     input logic ci,
                                                     output logic co, output logic ov);
        logic [DATA_W:0] s;
        s  = {1'b0, x} + {1'b0, y} + {{DATA_W{1'b0}}, ci};
        co = s[DATA_W];
        ov = (x[DATA_W-1] == y[DATA_W-1]) && (s[DATA_W-1] != x[DATA_W-1]);
        return s[DATA_W-1:0];
    endfunction

    function automatic t_alu_rsp alu_predict(input t_alu_req rq);
        logic [DATA_W-1:0] a, b, res, fsrc, src;
        logic              c, v, cmp, cin;
        int                sh;
        t_alu_rsp          rs;
        a    = rq.operand_a;
        b    = rq.operand_b;
        cin  = rq.use_carry_in & rq.flags_in[1];
        sh   = int'(b[SH_W-1:0]);
        res  = '0;
        fsrc = '0;
        c    = 1'b0;
        v    = 1'b0;
        cmp  = 1'b0;
        case (rq.opcode)
            OP_ADD, OP_ADD_A: res = add_carry(a, b, 1'b0, c, v);
            OP_SUB, OP_SUB_A: res = add_carry(a, ~b, 1'b1, c, v);
            OP_ADC, OP_ADC_A: res = add_carry(a, b, cin, c, v);
            OP_SBC, OP_SBC_A: res = add_carry(a, ~b, cin, c, v);
            OP_INC: begin
                res = a + 64'd1;
                c   = (res == '0);
                v   = (a == MAX_POS);
            end
            OP_DEC: begin
                res = a - 64'd1;
                c   = (a != '0);
                v   = (a == SIGN_MASK);
            end
            OP_AND, OP_AND_A: res = a & b;
            OP_ORR, OP_ORR_A: res = a | b;
            OP_EOR, OP_EOR_A: res = a ^ b;
            OP_BIC, OP_BIC_A: res = a & ~b;
            OP_LSL, OP_LSL_A: begin
                if (sh > 0) c = a[DATA_W-sh];
                res = a << sh;
            end
            OP_LSR, OP_LSR_A: begin
                if (sh > 0) c = a[sh-1];
                res = a >> sh;
            end
            OP_ASR, OP_ASR_A: begin
                if (sh > 0) c = a[sh-1];
                res = $unsigned($signed(a) >>> sh);
            end
            OP_ROR, OP_ROR_A: begin
                if (sh > 0) c = a[sh-1];
                res = (sh == 0) ? a : ((a >> sh) | (a << (DATA_W - sh)));
            end
            OP_MOV, OP_MOV_A, OP_MOV_B: res = b;
            OP_MVN, OP_MVN_A: res = ~b;
            OP_SFLIP: res = b ^ SIGN_MASK;
            OP_CMP, OP_CMP_A: begin
                fsrc = add_carry(a, ~b, 1'b1, c, v);
                cmp  = 1'b1;
            end
            OP_CMN, OP_CMN_A: begin
                fsrc = add_carry(a, b, 1'b0, c, v);
                cmp  = 1'b1;
            end
            OP_TST, OP_TST_A: begin
                fsrc = a & b;
                cmp  = 1'b1;
            end
            OP_TEQ, OP_TEQ_A: begin
                fsrc = a ^ b;
                cmp  = 1'b1;
            end
            default: res = '0;
        endcase
        src             = cmp ? fsrc : res;
        rs.result_value = res;
        rs.flags_out    = rq.update_flags ? {src[DATA_W-1], (src == '0), c, v} : 4'd0;
        rs.flags_valid  = rq.update_flags;
        rs.tag          = TAG_W'(rq.tag % TAG_ENTRIES);
        return rs;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual tag %0h",
                             $time, i_result_tag);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_value", want.result_value, i_result_value);
                    check_field("flags_out", DATA_W'(want.flags_out), DATA_W'(i_flags_out));
                    check_field("flags_valid", DATA_W'(want.flags_valid),
                                DATA_W'(i_flags_valid));
                    check_field("result_tag", DATA_W'(want.tag), DATA_W'(i_result_tag));
                end
            end
            if (i_req_valid && !i_req_stall) begin
                req_seen.opcode       = i_opcode;
                req_seen.operand_a    = i_operand_a;
                req_seen.operand_b    = i_operand_b;
                req_seen.flags_in     = i_flags_in;
                req_seen.use_carry_in = i_use_carry_in;
                req_seen.update_flags = i_update_flags;
                req_seen.tag          = i_dest_tag;
                pending_results.push_back(alu_predict(req_seen));
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fails;
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench top for integer_alu_with_flags: clock, reset, request stimulus and result stalls.
// Directed corner requests first, then random phases; depends on ialu_pkg and ialu_result_checker.
module tb;
    import ialu_pkg::*;

    localparam logic [DATA_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MAX_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [OP_W-1:0]   OP_UNUSED = 6'h04;
    localparam int                WATCHDOG_LIMIT = 1000;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_stall;
    logic [OP_W-1:0]   i_opcode       = '0;
    logic [DATA_W-1:0] i_operand_a    = '0;
    logic [DATA_W-1:0] i_operand_b    = '0;
    logic [3:0]        i_flags_in     = '0;
    logic              i_use_carry_in = 1'b0;
    logic              i_update_flags = 1'b0;
    logic [TAG_W-1:0]  i_dest_tag     = '0;
    logic              o_valid;
    logic              i_stall        = 1'b0;
    logic [DATA_W-1:0] o_result_value;
    logic [3:0]        o_flags_out;
    logic              o_flags_valid;
    logic [TAG_W-1:0]  o_result_tag;

    int fail_count;
    int results_due;
    int idle_cycles = 0;
    int stall_hold  = 0;
    bit src_idle    = 1'b0;
    bit sink_idle   = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    integer_alu_with_flags dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_flags_in     (i_flags_in),
        .i_use_carry_in (i_use_carry_in),
        .i_update_flags (i_update_flags),
        .i_dest_tag     (i_dest_tag),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_flags_out    (o_flags_out),
        .o_flags_valid  (o_flags_valid),
        .o_result_tag   (o_result_tag)
    );

    ialu_result_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_opcode       (i_opcode),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_flags_in     (i_flags_in),
        .i_use_carry_in (i_use_carry_in),
        .i_update_flags (i_update_flags),
        .i_dest_tag     (i_dest_tag),
        .i_rsp_valid    (o_valid),
        .i_rsp_stall    (i_stall),
        .i_result_value (o_result_value),
        .i_flags_out    (o_flags_out),
        .i_flags_valid  (o_flags_valid),
        .i_result_tag   (o_result_tag),
        .o_fail_count   (fail_count),
        .o_pending      (results_due)
    );

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (sink_idle && $urandom_range(0, 2) == 0) begin
            i_stall    <= 1'b1;
            stall_hold <= idle_len();
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] a, b,
                            input logic [3:0] fl, input logic uc, uf,
                            input logic [TAG_W-1:0] tg);
        int gap;
        i_opcode       <= op;
        i_operand_a    <= a;
        i_operand_b    <= b;
        i_flags_in     <= fl;
        i_use_carry_in <= uc;
        i_update_flags <= uf;
        i_dest_tag     <= tg;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        gap = src_idle ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // the pending count is registered in the checker, so it trails the last accepted request
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            2: return MAX_POS;
            3: return SIGN_MASK;
            4: return DATA_W'($urandom_range(0, 70));
            5: return ALL_ONES - DATA_W'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_opcode();
        if ($urandom_range(0, 4) == 0) return OP_W'($urandom_range(0, 63));
        case ($urandom_range(0, 22))
            0:  return OP_ADD;
            1:  return OP_SUB;
            2:  return OP_ADC;
            3:  return OP_SBC;
            4:  return OP_INC;
            5:  return OP_DEC;
            6:  return OP_AND;
            7:  return OP_ORR;
            8:  return OP_EOR;
            9:  return OP_BIC;
            10: return OP_LSL;
            11: return OP_LSR;
            12: return OP_ASR;
            13: return OP_ROR;
            14: return OP_MOV;
            15: return OP_MVN;
            16: return OP_SFLIP;
            17: return OP_CMP;
            18: return OP_CMN;
            19: return OP_TST;
            20: return OP_TEQ;
            21: return OP_UNUSED;
            default: return OP_ADC_A;
        endcase
    endfunction

    task automatic issue_random(input int count);
        logic [DATA_W-1:0] a, b;
        for (int n = 0; n < count; n++) begin
            a = rand_word();
            b = ($urandom_range(0, 9) == 0) ? a : rand_word();
            issue_op(pick_opcode(), a, b, 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)), ($urandom_range(0, 6) != 0),
                     TAG_W'($urandom_range(0, 63)));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue_op(OP_ADD,   ALL_ONES, 64'd1,     4'h0, 1'b0, 1'b1, 6'd0);
        issue_op(OP_ADD,   MAX_POS,  64'd1,     4'h0, 1'b0, 1'b1, 6'd63);
        issue_op(OP_SUB,   64'd0,    64'd1,     4'hF, 1'b1, 1'b1, 6'd1);
        issue_op(OP_ADC,   MAX_POS,  64'd0,     4'h2, 1'b1, 1'b1, 6'd2);
        issue_op(OP_ADC,   ALL_ONES, 64'd0,     4'h2, 1'b0, 1'b1, 6'd3);
        issue_op(OP_SBC,   64'd5,    ALL_ONES,  4'h0, 1'b1, 1'b1, 6'd4);
        issue_op(OP_SBC,   64'd5,    64'd3,     4'hF, 1'b1, 1'b1, 6'd5);
        issue_op(OP_INC,   MAX_POS,  64'd0,     4'h0, 1'b0, 1'b1, 6'd6);
        issue_op(OP_INC,   ALL_ONES, 64'd0,     4'h0, 1'b0, 1'b1, 6'd7);
        issue_op(OP_DEC,   64'd0,    64'd0,     4'h0, 1'b0, 1'b1, 6'd8);
        issue_op(OP_DEC,   SIGN_MASK, 64'd0,    4'h0, 1'b0, 1'b1, 6'd9);
        issue_op(OP_AND,   ALL_ONES, SIGN_MASK, 4'hF, 1'b1, 1'b1, 6'd10);
        issue_op(OP_ORR,   64'd0,    64'd0,     4'h0, 1'b0, 1'b1, 6'd11);
        issue_op(OP_EOR,   ALL_ONES, MAX_POS,   4'h0, 1'b0, 1'b1, 6'd12);
        issue_op(OP_BIC,   ALL_ONES, ALL_ONES,  4'h0, 1'b0, 1'b1, 6'd13);
        // shift by zero, by 63 and by 64 (wraps to zero)
        issue_op(OP_LSL,   ALL_ONES, 64'd0,     4'hF, 1'b1, 1'b1, 6'd14);
        issue_op(OP_LSL,   64'd3,    64'd63,    4'h0, 1'b0, 1'b1, 6'd15);
        issue_op(OP_LSR,   ALL_ONES, 64'd64,    4'h0, 1'b0, 1'b1, 6'd16);
        issue_op(OP_ASR,   SIGN_MASK | 64'd1, 64'd63, 4'h0, 1'b0, 1'b1, 6'd17);
        issue_op(OP_ROR,   64'd1,    64'd1,     4'h0, 1'b0, 1'b1, 6'd18);
        issue_op(OP_MVN,   64'd0,    ALL_ONES,  4'h0, 1'b0, 1'b1, 6'd19);
        issue_op(OP_SFLIP, 64'd0,    SIGN_MASK, 4'hF, 1'b1, 1'b0, 6'd20);
        issue_op(OP_CMP,   64'd42,   64'd42,    4'h0, 1'b0, 1'b1, 6'd21);
        issue_op(OP_CMN,   SIGN_MASK, SIGN_MASK, 4'h0, 1'b0, 1'b1, 6'd22);
        issue_op(OP_TST,   64'hF0,   64'h0F,    4'h0, 1'b0, 1'b1, 6'd23);
        issue_op(OP_TEQ,   ALL_ONES, 64'd0,     4'h0, 1'b0, 1'b1, 6'd24);
        issue_op(OP_UNUSED, ALL_ONES, ALL_ONES, 4'hF, 1'b1, 1'b1, 6'd25);
        issue_op(OP_MOV_B, 64'd0,    ALL_ONES,  4'h0, 1'b0, 1'b0, 6'd26);

        src_idle  <= 1'b1;
        sink_idle <= 1'b1;
        issue_random(600);

        drain_results();
        src_idle  <= 1'b0;
        sink_idle <= 1'b0;
        issue_random(450);

        src_idle  <= 1'b1;
        sink_idle <= 1'b1;
        issue_random(650);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
